// ===== hw/rtl/pid_controller_clamped_integral_macros.svh =====
// assertion macros for the pid controller rtl
// no dependencies; expects clock and reset in the including module
`ifndef PID_CONTROLLER_CLAMPED_INTEGRAL_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_INTEGRAL_MACROS_SVH

// same-cycle implication
`define PIDC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pidc_pkg.sv =====
// shared types, constants and saturation helpers of the pid controller
// no dependencies
`timescale 1ns / 1ps

package pidc_pkg;

   localparam int DATA_W    = 32;
   localparam int LIMIT_W   = 31;
   localparam int Q_FRAC    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int QUO_W     = PROD_W - 1;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEG  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MAX   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCUM_LIMIT = 3'd6;

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

   localparam logic [LIMIT_W-1:0] ACCUM_LIMIT_RST = 31'd3276800;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL_P,
      ST_MUL_E,
      ST_INC,
      ST_ACC,
      ST_MUL_I,
      ST_MUL_D,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SUM,
      ST_CLAMP,
      ST_FINISH
   } pidc_state_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   // floor(prod / 2^16) saturated to 32 bits
   function automatic logic signed [DATA_W-1:0] sat_q16(input logic signed [PROD_W-1:0] prod);
      logic [PROD_W-Q_FRAC-DATA_W:0] top;
      top = prod[PROD_W-1:Q_FRAC+DATA_W-1];
      if (top == '0 || top == '1) begin
         return prod[Q_FRAC+DATA_W-1:Q_FRAC];
      end else if (prod[PROD_W-1]) begin
         return S32_MIN;
      end else begin
         return S32_MAX;
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_33(input logic signed [DATA_W:0] v);
      if (v[DATA_W] == v[DATA_W-1]) begin
         return v[DATA_W-1:0];
      end else if (v[DATA_W]) begin
         return S32_MIN;
      end else begin
         return S32_MAX;
      end
   endfunction

endpackage

// ===== hw/rtl/pidc_div.sv =====
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on pidc_pkg
`timescale 1ns / 1ps

module pidc_div
   import pidc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [QUO_W-1:0]     dividend,
   input  logic [LIMIT_W-1:0]   divisor,
   output div_rsp_type          rsp
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [LIMIT_W-1:0] rem_ff, rem_in;
   logic [LIMIT_W-1:0] den_ff, den_in;
   logic [LIMIT_W:0]   trial;
   logic [LIMIT_W:0]   diff;

   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[LIMIT_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[LIMIT_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/pid_controller_clamped_integral.sv =====
// pid controller, clamped integral, derivative on measurement, q16.16
// depends on pidc_pkg, pidc_div and pid_controller_clamped_integral_macros.svh
//
// channel  direction  handshake          payload
// req      in         req_valid/ready    action, sample, step_time
// rsp      out        rsp_valid/ready    drive, skipped
// csr      in         csr_we             csr_index, csr_wdata
//
// a compute transaction runs the 63-step serial divider for the derivative term
// after one shared 32x32 multiplier used four times in sequence; clear and skip
// requests go from idle straight to the finish state.
// req_ready is high only when the sequencer is idle; a finished result waits in
// the output register, so the next transaction can be taken while rsp stalls.
// sync reset restores only the state, rsp_valid, integral, last sample and csrs
`timescale 1ns / 1ps
`include "pid_controller_clamped_integral_macros.svh"

module pid_controller_clamped_integral
   import pidc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic signed [DATA_W-1:0]    req_sample,
   input  logic signed [DATA_W-1:0]    req_step_time,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DATA_W-1:0]    rsp_drive,
   output logic                        rsp_skipped,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata
);

   pidc_state_type st_ff, st_in;

   logic signed [DATA_W-1:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff, target_ff;
   logic signed [DATA_W-1:0] drive_min_ff, drive_max_ff;
   logic [LIMIT_W-1:0]       limit_ff;

   logic signed [DATA_W-1:0] integ_ff, integ_in;
   logic signed [DATA_W-1:0] last_ff, last_in;

   logic signed [DATA_W-1:0] sample_ff, sample_in;
   logic signed [DATA_W-1:0] dt_ff, dt_in;
   logic signed [DATA_W-1:0] err_ff, err_in;
   logic signed [DATA_W-1:0] delta_ff, delta_in;
   logic signed [DATA_W-1:0] p_ff, p_in;
   logic signed [DATA_W-1:0] inc_ff, inc_in;
   logic signed [DATA_W-1:0] i_ff, i_in;
   logic signed [DATA_W-1:0] d_ff, d_in;
   logic signed [DATA_W+1:0] sum_ff, sum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic signed [DATA_W-1:0] res_drive_ff, res_drive_in;
   logic                     res_skip_ff, res_skip_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic                     rsp_skip_ff, rsp_skip_in;

   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [DATA_W:0]   acc_sum, lim_pos, lim_neg;
   logic signed [DATA_W+1:0] dmax_ext, dmin_ext;
   logic [PROD_W-1:0]        prod_abs;
   logic                     div_start;
   div_rsp_type              div_rsp;
   logic                     req_fire;
   logic                     q_big;

   assign req_ready = (st_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // shared multiplier
   always_comb begin
      case (st_ff)
         ST_MUL_P: begin
            mul_a = gain_prop_ff;
            mul_b = err_ff;
         end
         ST_MUL_E: begin
            mul_a = err_ff;
            mul_b = dt_ff;
         end
         ST_MUL_I: begin
            mul_a = gain_integ_ff;
            mul_b = integ_ff;
         end
         ST_MUL_D: begin
            mul_a = gain_deriv_ff;
            mul_b = delta_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = $signed(mul_a) * $signed(mul_b);
   assign prod_abs = prod_ff[PROD_W-1] ? (~prod_ff + PROD_W'(1)) : prod_ff;

   assign acc_sum  = {integ_ff[DATA_W-1], integ_ff} + {inc_ff[DATA_W-1], inc_ff};
   assign lim_pos  = {2'b00, limit_ff};
   assign lim_neg  = -lim_pos;
   assign dmax_ext = {{2{drive_max_ff[DATA_W-1]}}, drive_max_ff};
   assign dmin_ext = {{2{drive_min_ff[DATA_W-1]}}, drive_min_ff};
   assign q_big    = |div_rsp.quotient[QUO_W-1:DATA_W-1];

   pidc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_abs[QUO_W-1:0]),
      .divisor  (dt_ff[LIMIT_W-1:0]),
      .rsp      (div_rsp)
   );

   always_comb begin
      st_in        = st_ff;
      integ_in     = integ_ff;
      last_in      = last_ff;
      sample_in    = sample_ff;
      dt_in        = dt_ff;
      err_in       = err_ff;
      delta_in     = delta_ff;
      p_in         = p_ff;
      inc_in       = inc_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      sum_in       = sum_ff;
      neg_in       = neg_ff;
      res_drive_in = res_drive_ff;
      res_skip_in  = res_skip_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_drive_in = rsp_drive_ff;
      rsp_skip_in  = rsp_skip_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in = req_sample;
               dt_in     = req_step_time;
               if (req_action) begin
                  integ_in     = '0;
                  last_in      = '0;
                  res_drive_in = '0;
                  res_skip_in  = 1'b0;
                  st_in        = ST_FINISH;
               end else if (req_step_time[DATA_W-1] || req_step_time == '0) begin
                  res_drive_in = '0;
                  res_skip_in  = 1'b1;
                  st_in        = ST_FINISH;
               end else begin
                  st_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            err_in   = sat_33({target_ff[DATA_W-1], target_ff}
                              - {sample_ff[DATA_W-1], sample_ff});
            delta_in = sat_33({sample_ff[DATA_W-1], sample_ff}
                              - {last_ff[DATA_W-1], last_ff});
            last_in  = sample_ff;
            st_in    = ST_MUL_P;
         end
         ST_MUL_P: begin
            st_in = ST_MUL_E;
         end
         ST_MUL_E: begin
            p_in  = sat_q16(prod_ff);
            st_in = ST_INC;
         end
         ST_INC: begin
            inc_in = sat_q16(prod_ff);
            st_in  = ST_ACC;
         end
         ST_ACC: begin
            if (acc_sum > lim_pos) begin
               integ_in = lim_pos[DATA_W-1:0];
            end else if (acc_sum < lim_neg) begin
               integ_in = lim_neg[DATA_W-1:0];
            end else begin
               integ_in = acc_sum[DATA_W-1:0];
            end
            st_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            st_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            i_in  = sat_q16(prod_ff);
            st_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            neg_in    = prod_ff[PROD_W-1];
            st_in     = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               // d is minus the truncated quotient
               if (neg_ff) begin
                  d_in = q_big ? S32_MAX : div_rsp.quotient[DATA_W-1:0];
               end else begin
                  d_in = q_big ? S32_MIN : (~div_rsp.quotient[DATA_W-1:0] + DATA_W'(1));
               end
               st_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in = {{2{p_ff[DATA_W-1]}}, p_ff} + {{2{i_ff[DATA_W-1]}}, i_ff}
                     + {{2{d_ff[DATA_W-1]}}, d_ff};
            st_in  = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (sum_ff > dmax_ext) begin
               res_drive_in = drive_max_ff;
            end else if (sum_ff < dmin_ext) begin
               res_drive_in = drive_min_ff;
            end else begin
               res_drive_in = sum_ff[DATA_W-1:0];
            end
            res_skip_in = 1'b0;
            st_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = res_drive_ff;
               rsp_skip_in  = res_skip_ff;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_ff      <= '0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= '0;
         gain_integ_ff <= '0;
         gain_deriv_ff <= '0;
         target_ff     <= '0;
         drive_min_ff  <= S32_MIN;
         drive_max_ff  <= S32_MAX;
         limit_ff      <= ACCUM_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN_PROP:   gain_prop_ff  <= csr_wdata;
            CSR_GAIN_INTEG:  gain_integ_ff <= csr_wdata;
            CSR_GAIN_DERIV:  gain_deriv_ff <= csr_wdata;
            CSR_TARGET:      target_ff     <= csr_wdata;
            CSR_DRIVE_MIN:   drive_min_ff  <= csr_wdata;
            CSR_DRIVE_MAX:   drive_max_ff  <= csr_wdata;
            CSR_ACCUM_LIMIT: limit_ff      <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      dt_ff        <= dt_in;
      err_ff       <= err_in;
      delta_ff     <= delta_in;
      p_ff         <= p_in;
      inc_ff       <= inc_in;
      i_ff         <= i_in;
      d_ff         <= d_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      res_drive_ff <= res_drive_in;
      res_skip_ff  <= res_skip_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_skip_ff  <= rsp_skip_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_skipped = rsp_skip_ff;

   `PIDC_ASSERT_NEXT(a_accept_leaves_idle, req_fire, st_ff != ST_IDLE, "sequencer stayed idle after accept")
   `PIDC_ASSERT_IMPL(a_integ_in_limit, st_ff == ST_MUL_I, integ_ff <= lim_pos && integ_ff >= lim_neg, "integral outside limit")
   `PIDC_ASSERT_IMPL(a_skip_zero_drive, rsp_valid && rsp_skipped, rsp_drive == '0, "skipped transaction with nonzero drive")
   `PIDC_ASSERT_IMPL(a_div_done_waiting, div_rsp.done, st_ff == ST_DIV_WAIT, "divider finished outside wait state")

endmodule
